// ----- rtl/instruction_miss_line_buffer_macros.svh -----
// assertion helpers used by the rtl top module
`ifndef INSTRUCTION_MISS_LINE_BUFFER_MACROS_SVH
`define INSTRUCTION_MISS_LINE_BUFFER_MACROS_SVH

// same-cycle implication, checked outside reset
`define IMLB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define IMLB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/imlb_pkg.sv -----
package imlb_pkg;

  localparam int IMLB_LINES = 8;
  localparam int LINE_WORDS = 4;
  localparam int LANE_W     = 2;

  localparam int IN_W  = 72;
  localparam int OUT_W = 72;

  localparam logic [31:0] STEP_W1 = 32'h4;
  localparam logic [31:0] STEP_W2 = 32'h8;
  localparam logic [31:0] STEP_W3 = 32'hC;

  typedef enum logic [1:0] {
    KIND_HIT  = 2'd0,
    KIND_FWD  = 2'd1,
    KIND_FILL = 2'd2
  } kind_t;

  typedef enum logic {
    ACT_REQ  = 1'b0,
    ACT_FILL = 1'b1
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RD,
    ST_WORD,
    ST_ONE
  } state_t;

  // strobes from the controller to the line store
  typedef struct packed {
    logic row_rd;
    logic word_rd;
    logic wr;
  } store_ctl_t;

endpackage

// ----- rtl/instruction_miss_line_buffer.sv -----
// instruction miss line buffer
// s_* carries items from the cores and from memory: tuser is the action
// (0 core request, 1 fill beat), tlast marks the final beat of a fill burst.
// m_* carries results: tuser is the kind (0 hit word, 1 forward to memory,
// 2 fill word passed to the core), tlast marks the last result of an item.
// one item is worked at a time. after acceptance the lines are scanned one
// per cycle from line 0 through the address store read port, stopping at the
// first full match or after the last line. a miss or a fill beat then yields
// its single result from ST_ONE; a hit reads the data store once per word
// (ST_RD, then ST_WORD), up to four words, and none for a zero burst.
// reset clears the fill pointer and the per-word valid bits, so no clearing
// pass is needed and the block takes requests right away.
// a finished result sits in the output register until taken; the next item
// is accepted meanwhile, and the block only waits when a new result is due
// while the output register is still full.
`include "instruction_miss_line_buffer_macros.svh"

module instruction_miss_line_buffer import imlb_pkg::*; #(
  parameter int LINES = IMLB_LINES,
  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // requester[2:0], line_address[34:3], burst_length[37:35],
  // beat_index[39:38], fill_word[71:40]
  input  logic [IN_W-1:0]  s_tdata,
  input  logic             s_tuser,  // action
  input  logic             s_tlast,  // final_beat
  output logic             m_tvalid,
  input  logic             m_tready,
  // target_core[2:0], out_address[34:3], out_burst[37:35],
  // word_data[69:38], zero[71:70]
  output logic [OUT_W-1:0] m_tdata,
  output logic [1:0]       m_tuser,  // kind
  output logic             m_tlast   // last_word
);

  state_t state, state_next;

  // captured item
  action_t                     act;
  logic [2:0]                  core;
  logic [LINE_WORDS-1:0][31:0] adr;
  logic [2:0]                  burst;
  logic [2:0]                  n;
  logic [LANE_W-1:0]           beat;
  logic [31:0]                 fword;
  logic                        fin;

  logic [LW-1:0]     cnt;
  logic [LW-1:0]     match_row;
  logic [LANE_W-1:0] k;
  logic [LW-1:0]     fill_ptr;

  store_ctl_t                  ctl;
  logic [LW-1:0]               rd_row;
  logic [LINE_WORDS-1:0][31:0] row_addr;
  logic [LINE_WORDS-1:0]       row_vld;
  logic [31:0]                 word_data;

  logic        row_hit;
  logic        last_line;
  logic        word_last;
  logic        out_free;
  logic        out_load;
  logic        s_accept;
  kind_t       res_kind;
  logic [31:0] res_addr;
  logic [2:0]  res_burst;
  logic [31:0] res_data;
  logic        res_last;

  logic [31:0] in_addr;
  logic [2:0]  in_burst;

  assign in_addr  = s_tdata[34:3];
  assign in_burst = s_tdata[37:35];
  assign s_accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    row_hit = &row_vld;
    for (int w = 0; w < LINE_WORDS; w++) begin
      row_hit = row_hit && (row_addr[w] == adr[w]);
    end
  end

  assign last_line = (cnt == LW'(LINES - 1));
  assign word_last = (({1'b0, k} + 3'd1) == n);

  imlb_store #(.LINES(LINES)) u_store (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .rd_row    (rd_row),
    .word_idx  ({match_row, k}),
    .wr_row    (fill_ptr),
    .wr_lane   (beat),
    .wr_addr   (adr[beat]),
    .wr_data   (fword),
    .row_addr  (row_addr),
    .row_vld   (row_vld),
    .word_data (word_data)
  );

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    ctl        = '0;
    rd_row     = '0;
    out_load   = 1'b0;
    res_kind   = KIND_HIT;
    res_addr   = '0;
    res_burst  = '0;
    res_data   = '0;
    res_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          ctl.row_rd = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (row_hit) begin
          if (act == ACT_FILL) begin
            state_next = ST_ONE;
          end else if (n == 3'd0) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RD;
          end
        end else if (last_line) begin
          // line absent: a fill beat lands under the fill pointer
          ctl.wr     = (act == ACT_FILL);
          state_next = ST_ONE;
        end else begin
          ctl.row_rd = 1'b1;
          rd_row     = cnt + LW'(1);
        end
      end
      ST_RD: begin
        ctl.word_rd = 1'b1;
        state_next  = ST_WORD;
      end
      ST_WORD: begin
        res_kind = KIND_HIT;
        res_data = word_data;
        res_last = word_last;
        if (out_free) begin
          out_load   = 1'b1;
          state_next = word_last ? ST_IDLE : ST_RD;
        end
      end
      ST_ONE: begin
        res_last = 1'b1;
        if (act == ACT_FILL) begin
          res_kind = KIND_FILL;
          res_data = fword;
        end else begin
          res_kind  = KIND_FWD;
          res_addr  = adr[0];
          res_burst = burst;
        end
        if (out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      act    <= action_t'(s_tuser);
      core   <= s_tdata[2:0];
      adr[0] <= in_addr;
      adr[1] <= in_addr + STEP_W1;
      adr[2] <= in_addr + STEP_W2;
      adr[3] <= in_addr + STEP_W3;
      burst  <= in_burst;
      n      <= (in_burst > 3'd4) ? 3'd4 : in_burst;
      beat   <= s_tdata[39:38];
      fword  <= s_tdata[71:40];
      fin    <= s_tlast;
      cnt    <= '0;
    end else if (ctl.row_rd) begin
      cnt <= cnt + LW'(1);
    end
    if (state == ST_SCAN && row_hit) begin
      match_row <= cnt;
      k         <= '0;
    end else if (out_load && state == ST_WORD) begin
      k <= k + LANE_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_ptr <= '0;
    end else if (ctl.wr && fin) begin
      fill_ptr <= (fill_ptr == LW'(LINES - 1)) ? '0 : fill_ptr + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, res_data, res_burst, res_addr, core};
      m_tuser <= res_kind;
      m_tlast <= res_last;
    end
  end

  `IMLB_ASSERT_NOW(a_load_free, out_load, !m_tvalid || m_tready, "result overwrote a pending one")
  `IMLB_ASSERT_NOW(a_wr_on_miss, ctl.wr, !row_hit && last_line && act == ACT_FILL, "write on hit")
  `IMLB_ASSERT_NEXT(a_ptr_hold, !(ctl.wr && fin), $stable(fill_ptr), "fill pointer moved")
  `IMLB_ASSERT_NEXT(a_accept_scan, s_accept, state == ST_SCAN, "accept did not start a scan")

endmodule

// ----- rtl/imlb_store.sv -----
module imlb_store import imlb_pkg::*; #(
  parameter int LINES = IMLB_LINES,
  localparam int LW = (LINES > 1) ? $clog2(LINES) : 1
) (
  input  logic                              clk,
  input  logic                              rst,
  input  store_ctl_t                        ctl,
  input  logic [LW-1:0]                     rd_row,
  input  logic [LW+LANE_W-1:0]              word_idx,
  input  logic [LW-1:0]                     wr_row,
  input  logic [LANE_W-1:0]                 wr_lane,
  input  logic [31:0]                       wr_addr,
  input  logic [31:0]                       wr_data,
  output logic [LINE_WORDS-1:0][31:0]       row_addr,
  output logic [LINE_WORDS-1:0]             row_vld,
  output logic [31:0]                       word_data
);

  // address store is one row per line so a whole line compares at once
  logic [LINE_WORDS-1:0][31:0] addr_mem [LINES];
  logic [31:0]                 data_mem [LINES*LINE_WORDS];
  logic [LINES-1:0][LINE_WORDS-1:0] vld;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      addr_mem[wr_row][wr_lane] <= wr_addr;
      data_mem[{wr_row, wr_lane}] <= wr_data;
    end
    if (ctl.row_rd) begin
      row_addr <= addr_mem[rd_row];
      row_vld  <= vld[rd_row];
    end
    if (ctl.word_rd) begin
      word_data <= data_mem[word_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (ctl.wr) begin
      vld[wr_row][wr_lane] <= 1'b1;
    end
  end

endmodule
